// ===== rtl/core/sbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants
// Defaults, port widths, back-end state type and the BCD doubling helper for
// the signed binary to decimal digit converter.
// ----------------------------------------------------------------------------
package sbd_pkg;

    // default sizes
    localparam int VALUE_BITS_DEF = 128;
    localparam int MAX_DIGITS_DEF = 39;

    // port widths
    localparam int HALF_W     = 64;
    localparam int IN_DATA_W  = 2 * HALF_W;
    localparam int DIGIT_W    = 4;
    localparam int OUT_DATA_W = 8;

    // decimal base and the threshold at which doubling carries out
    localparam logic [4:0] DEC_BASE  = 5'd10;
    localparam logic [3:0] CARRY_MIN = 4'd5;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } sbd_state_t;

    // one BCD digit doubled plus the carry from the digit below, mod 10
    function automatic logic [3:0] dbl_digit(input logic [3:0] old, input logic cin);
        logic [4:0] sum;
        sum = {old, cin};
        if (old >= CARRY_MIN)
        begin
            sum = sum - DEC_BASE;
        end
        return sum[3:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sbd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_front: input stage
// Accepts a transaction, takes the sign and forms the magnitude, and hands
// the result to the queue when there is room.
// ----------------------------------------------------------------------------
module sbd_front #(
    parameter int VALUE_BITS = sbd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sbd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           q_full,
    output logic                                push,
    output logic                                push_neg,
    output logic [VALUE_BITS-1:0]               push_mag
);

    logic                  valid_reg, valid_next;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [sbd_pkg::IN_DATA_W-1:0] value_full;
    logic [VALUE_BITS-1:0] value;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  accept;

    // tdata holds value_high low, value_low high; rebuild the 128-bit word
    assign value_full = {s_tdata[sbd_pkg::HALF_W-1:0],
                         s_tdata[sbd_pkg::IN_DATA_W-1:sbd_pkg::HALF_W]};
    assign value      = value_full[VALUE_BITS-1:0];

    // sign and magnitude; the most negative value negates to itself
    assign in_neg = value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

    // handshake
    assign push     = valid_reg && !q_full;
    assign s_tready = !valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= in_neg;
            mag_reg <= in_mag;
        end
    end

    assign push_neg = neg_reg;
    assign push_mag = mag_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sbd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_queue: two-entry queue
// Holds sign and magnitude between the input stage and the converter.
// ----------------------------------------------------------------------------
module sbd_queue #(
    parameter int VALUE_BITS = sbd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic                  push_neg,
    input  wire logic [VALUE_BITS-1:0] push_mag,
    input  wire logic                  pop,
    output logic                       q_full,
    output logic                       q_empty,
    output logic                       pop_neg,
    output logic [VALUE_BITS-1:0]      pop_mag
);

    logic [VALUE_BITS:0] mem [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                do_push, do_pop;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= {push_neg, push_mag};
        end
    end

    assign pop_neg = mem[rd_ptr_reg][VALUE_BITS];
    assign pop_mag = mem[rd_ptr_reg][VALUE_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/sbd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_back: double dabble converter and digit emitter
// Shifts one magnitude bit per cycle into a BCD register, then walks the
// digits from the top, drops leading zeros and drives the output register.
// ----------------------------------------------------------------------------
module sbd_back #(
    parameter int VALUE_BITS = sbd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sbd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    input  wire logic                            pop_neg,
    input  wire logic [VALUE_BITS-1:0]           pop_mag,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sbd_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_W = $clog2(MAX_DIGITS);

    sbd_pkg::sbd_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [3:0]            digits_reg [MAX_DIGITS];
    logic [3:0]            digits_next [MAX_DIGITS];
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]      dig_cnt_reg, dig_cnt_next;
    logic                  started_reg, started_next;

    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            out_digit_reg, out_digit_next;
    logic                  out_neg_reg, out_neg_next;
    logic                  out_last_reg, out_last_next;

    logic                  slot_free;
    logic                  take;
    logic [3:0]            top_digit;

    assign slot_free = !out_valid_reg || m_tready;
    assign top_digit = digits_reg[MAX_DIGITS-1];
    assign take      = started_reg || (top_digit != 4'd0) || (dig_cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbd_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = sbd_pkg::ST_CONV;
                end
            end
            sbd_pkg::ST_CONV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = sbd_pkg::ST_EMIT;
                end
            end
            sbd_pkg::ST_EMIT:
            begin
                if (slot_free && (dig_cnt_reg == '0))
                begin
                    state_next = sbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        pop            = 1'b0;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        digits_next    = digits_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_digit_next = out_digit_reg;
        out_neg_next   = out_neg_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            sbd_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop          = 1'b1;
                    mag_next     = pop_mag;
                    neg_next     = pop_neg;
                    bit_cnt_next = CNT_W'(VALUE_BITS - 1);
                    for (int i = 0; i < MAX_DIGITS; i++)
                    begin
                        digits_next[i] = 4'd0;
                    end
                end
            end
            sbd_pkg::ST_CONV:
            begin
                // every digit doubles at once; carry in comes from the old digit below
                digits_next[0] = sbd_pkg::dbl_digit(digits_reg[0], mag_reg[VALUE_BITS-1]);
                for (int i = 1; i < MAX_DIGITS; i++)
                begin
                    digits_next[i] = sbd_pkg::dbl_digit(digits_reg[i],
                                         digits_reg[i-1] >= sbd_pkg::CARRY_MIN);
                end
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                dig_cnt_next = DIG_W'(MAX_DIGITS - 1);
                started_next = 1'b0;
            end
            sbd_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    // top digit leaves; leading zeros are skipped
                    for (int i = 1; i < MAX_DIGITS; i++)
                    begin
                        digits_next[i] = digits_reg[i-1];
                    end
                    digits_next[0] = 4'd0;
                    dig_cnt_next   = dig_cnt_reg - DIG_W'(1);
                    if (take)
                    begin
                        started_next   = 1'b1;
                        out_valid_next = 1'b1;
                        out_digit_next = top_digit;
                        out_neg_next   = neg_reg;
                        out_last_next  = (dig_cnt_reg == '0);
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            started_reg   <= started_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        digits_reg    <= digits_next;
        out_digit_reg <= out_digit_next;
        out_neg_reg   <= out_neg_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sbd_pkg::OUT_DATA_W - sbd_pkg::DIGIT_W){1'b0}}, out_digit_reg};
    assign m_tuser  = out_neg_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/signed_binary_to_decimal_digits.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_digits: signed binary to decimal digit stream
// Converts one two's-complement value into its decimal digits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transaction carries a VALUE_BITS-bit two's-complement
//   value as two 64-bit halves. Bits above VALUE_BITS are ignored.
//   Output channel m_*: one transaction per decimal digit, most significant
//   first, leading zeros dropped; zero gives a single 0. m_tuser is the sign
//   of the input on every digit, m_tlast marks the least significant digit.
//   Flow: the input stage registers the item, the converter pops it from the
//   queue, runs double dabble (one magnitude bit per cycle) and then walks
//   the digit register, one digit per cycle while the receiver takes them.
//   The single converter handles one item at a time; it pops the next item
//   only after the digit walk of the current one has ended.
//   A two-entry queue and the input register hold up to three further items.
//   Reset clears all control state; no output is valid after reset.
//   When the receiver stalls, the output register holds its transaction and
//   the digit walk pauses; the input side keeps taking items until the queue
//   and the input register are full.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_digits #(
    parameter int VALUE_BITS = sbd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sbd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [63:0] value_high, [127:64] value_low
    input  wire logic [sbd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [3:0] digit, [7:4] zero
    output logic [sbd_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] is_negative
    output logic                                m_tuser,
    output logic                                m_tlast
);

    logic                  push;
    logic                  push_neg;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  pop;
    logic                  pop_neg;
    logic [VALUE_BITS-1:0] pop_mag;
    logic                  q_full;
    logic                  q_empty;

    sbd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_neg (push_neg),
        .push_mag (push_mag)
    );

    sbd_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_neg (push_neg),
        .push_mag (push_mag),
        .pop      (pop),
        .q_full   (q_full),
        .q_empty  (q_empty),
        .pop_neg  (pop_neg),
        .pop_mag  (pop_mag)
    );

    sbd_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .pop_neg  (pop_neg),
        .pop_mag  (pop_mag),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // the input stage only writes into a queue with room
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("push into full queue");

    // the converter only takes from a queue that holds an item
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
        else $error("pop from empty queue");

    // every emitted digit is a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9))
        else $error("digit out of range");

    // the sign does not change between digits of one item
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |-> m_tuser == $past(m_tuser))
        else $error("sign changed within an item");

endmodule
`default_nettype wire

// ===== tb/signed_binary_to_decimal_digits_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_digits_test: digit stream checker
// Sends signed 128-bit values into the converter and checks every decimal
// digit that comes out against digits worked out here by repeated division
// by ten. The directed values cover zero, +-1, the extremes, the most
// negative value and power-of-ten boundaries. Random values of mixed
// magnitudes and signs follow. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_digits_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 250;
    localparam int LONG_HOLD = 2000;

    // one expected output transaction
    typedef struct packed {
        logic [3:0] digit;
        logic       is_negative;
        logic       last_digit;
    } dec_digit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // [63:0] value_high, [127:64] value_low
    logic [sbd_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [3:0] digit, [7:4] zero
    logic [sbd_pkg::OUT_DATA_W-1:0] m_tdata;
    // [0] is_negative
    logic m_tuser;
    logic m_tlast;

    logic [127:0] values_pending[$];   // {value_high, value_low}
    dec_digit_t   digits_due[$];
    int           errors = 0;
    int           values_sent = 0;
    int           cycles = 0;
    bit           no_idle = 1'b0;
    bit           long_hold_done = 1'b0;
    int           send_gap = 0;
    int           recv_stall = 0;

    signed_binary_to_decimal_digits dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // decimal digits of one value, most significant first
    task automatic queue_decimal_digits(input logic [127:0] value);
        logic [127:0] mag;
        logic         neg;
        logic [3:0]   rev[$];
        int           n;
        dec_digit_t   d;
        neg = value[127];
        mag = neg ? (~value + 128'd1) : value;
        do
        begin
            rev.push_front(4'(mag % 128'd10));
            mag = mag / 128'd10;
        end
        while (mag != 0);
        n = rev.size();
        for (int i = 0; i < n; i++)
        begin
            d.digit       = rev[i];
            d.is_negative = neg;
            d.last_digit  = (i == n - 1);
            digits_due.insert(digits_due.size(), d);
        end
    endtask

    // append one value to the pending list
    task automatic add_value(input logic [127:0] v);
        values_pending.insert(values_pending.size(), v);
    endtask

    function automatic logic [127:0] ten_to(input int k);
        logic [127:0] p;
        p = 128'd1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 128'd10;
        end
        return p;
    endfunction

    function automatic logic [127:0] random_value();
        logic [127:0] v;
        logic [127:0] mask;
        int           pick;
        int           nbits;
        pick = $urandom_range(0, 7);
        v = {$urandom, $urandom, $urandom, $urandom};
        if (pick == 0)
        begin
            // near a power of ten
            v = ten_to($urandom_range(0, 38)) - 128'($urandom_range(0, 1));
        end
        else if (pick <= 5)
        begin
            // random magnitude size, up to 127 bits
            nbits = $urandom_range(0, 127);
            mask = (nbits == 0) ? 128'd0 : ({128{1'b1}} >> (128 - nbits));
            v = v & mask;
        end
        if (pick <= 5 && $urandom_range(0, 1) == 1)
        begin
            v = ~v + 128'd1;
        end
        return v;
    endfunction

    // send side: one item per transaction, random gap after each unless no_idle is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                queue_decimal_digits({s_tdata[63:0], s_tdata[127:64]});
                values_sent++;
                send_gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (values_pending.size() > 0)
                begin
                    logic [127:0] v;
                    v = values_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {v[63:0], v[127:64]};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receive side: check each digit, random stalls, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (digits_due.size() == 0)
                begin
                    $error("unexpected digit transaction: digit %0d", m_tdata[3:0]);
                    errors++;
                end
                else
                begin
                    dec_digit_t want;
                    want = digits_due.pop_front();
                    if (m_tdata[3:0] !== want.digit)
                    begin
                        $error("digit: expected %0d, got %0d", want.digit, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tuser !== want.is_negative)
                    begin
                        $error("is_negative: expected %0d, got %0d",
                               want.is_negative, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last_digit)
                    begin
                        $error("last_digit: expected %0d, got %0d",
                               want.last_digit, m_tlast);
                        errors++;
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            // long hold-off once the random stream is underway
            if (!long_hold_done && values_sent >= 40)
            begin
                long_hold_done = 1'b1;
                recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_all_done();
        do
        begin
            @(negedge clk);
        end
        while (values_pending.size() != 0 || s_tvalid || digits_due.size() != 0);
    endtask

    // stimulus
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed values
        add_value(128'd0);
        add_value(128'd1);
        add_value({128{1'b1}});                  // -1
        add_value(128'd9);
        add_value(128'd10);
        add_value(~128'd10 + 128'd1);            // -10
        add_value({1'b0, {127{1'b1}}});          // largest positive
        add_value({1'b1, 127'd0});               // most negative
        add_value({1'b1, 126'd0, 1'b1});         // most negative + 1
        add_value({64'd1, 64'd0});               // 2^64
        add_value({64'd0, {64{1'b1}}});          // 2^64 - 1
        add_value({{64{1'b1}}, 64'd0});          // -2^64
        add_value(ten_to(38));
        add_value(ten_to(38) - 128'd1);
        add_value(~(ten_to(38) - 128'd1) + 128'd1);
        add_value(ten_to(19));
        add_value(128'd99);
        add_value(128'd100);
        add_value({{32{4'h5}}});
        add_value({{32{4'ha}}});
        add_value(128'd123456789012345678901234567890);
        wait_all_done();

        // random values with idling on both sides
        for (int i = 0; i < 150; i++)
        begin
            add_value(random_value());
        end
        wait_all_done();

        // back-to-back stretch
        no_idle = 1'b1;
        for (int i = 0; i < 60; i++)
        begin
            add_value(random_value());
        end
        wait_all_done();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
